// ----- rtl/core/tst_pkg.sv -----
// shared types and constants for the transaction snapshot table
// request and result structs, request codes, controller command struct
// no dependencies
package tst_pkg;

    localparam int DEF_NUM_SLOTS = 32;
    localparam int ID_W          = 32;
    localparam int SLOT_W        = 5;
    localparam int CNT_W         = 6;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_END    = 2'd1;
    localparam logic [1:0] REQ_SNAP   = 2'd2;
    localparam logic [1:0] REQ_ASSIGN = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   txn_id;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]  entry_id;
        logic [CNT_W-1:0] active_count;
        logic [ID_W-1:0]  min_active;
        logic [ID_W-1:0]  upper_bound;
        logic             is_last;
    } t_rsp;

    typedef struct packed {
        logic add;
        logic end_rd;
        logic end_upd;
        logic assign_id;
        logic snap_start;
        logic scan_rd;
        logic scan_chk;
        logic emit_sum;
    } t_cmd;

endpackage

// ----- rtl/core/tst_ctrl.sv -----
// controller for the transaction snapshot table
// decodes add and assign, sequences end, snapshot scan and summary; depends on tst_pkg
module tst_ctrl import tst_pkg::*; #(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int AW        = $clog2(NUM_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_req_type,
    output logic          o_busy,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_scan_addr
);

    localparam int IDX_W = $clog2(NUM_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_SUM  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             w_accept;
    logic             w_scan_done;

    assign w_accept    = i_start && (r_state == ST_IDLE);
    assign w_scan_done = (r_idx == IDX_W'(NUM_SLOTS));

    always_comb begin
        o_cmd            = '0;
        o_cmd.add        = w_accept && (i_req_type == REQ_ADD);
        o_cmd.end_rd     = w_accept && (i_req_type == REQ_END);
        o_cmd.assign_id  = w_accept && (i_req_type == REQ_ASSIGN);
        o_cmd.snap_start = w_accept && (i_req_type == REQ_SNAP);
        o_cmd.end_upd    = (r_state == ST_END);
        o_cmd.scan_chk   = (r_state == ST_SCAN);
        o_cmd.scan_rd    = (r_state == ST_SCAN) && !w_scan_done;
        o_cmd.emit_sum   = (r_state == ST_SUM);
    end

    assign o_scan_addr = r_idx[AW-1:0];
    assign o_busy      = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.end_rd) begin
                    n_state = ST_END;
                end else if (o_cmd.snap_start) begin
                    // read of slot zero goes out with the accept
                    n_state = ST_SCAN;
                    n_idx   = IDX_W'(1);
                end
            end
            ST_END: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = ST_SUM;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_SUM: begin
                n_state = ST_IDLE;
                n_idx   = '0;
            end
            default: begin
                n_state = ST_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ----- rtl/core/tst_dp.sv -----
// datapath for the transaction snapshot table
// slot memory with valid bits, counters, scan accumulators, result register; depends on tst_pkg
module tst_dp import tst_pkg::*; #(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int AW        = $clog2(NUM_SLOTS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  logic [AW-1:0]   i_scan_addr,
    input  t_req            i_req,
    input  logic            i_cfg_wr,
    input  logic [ID_W-1:0] i_cfg_data,
    output logic [ID_W-1:0] o_floor,
    output t_rsp            o_rsp,
    output logic            o_rsp_valid
);

    localparam int SX_W = SLOT_W + 1;

    logic [ID_W-1:0]      mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;

    logic [ID_W-1:0]  r_rd_data;
    logic             r_rd_val;
    logic [AW-1:0]    r_rd_idx;

    logic [SX_W-1:0]  r_req_slot;
    logic             r_req_in_range;

    logic [ID_W-1:0]  r_latest_done;
    logic [ID_W-1:0]  r_next_id;
    logic [ID_W-1:0]  r_reject_floor;
    logic [ID_W-1:0]  r_min, n_min;
    logic [ID_W-1:0]  r_ub;
    logic [CNT_W-1:0] r_cnt;

    t_rsp             r_rsp, n_rsp;
    logic             r_rsp_valid, n_rsp_valid;

    logic [SX_W-1:0]  w_slot_x;
    logic             w_in_range;
    logic [AW-1:0]    w_slot_idx;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic [ID_W-1:0]  w_rd_id;
    logic             w_hit;

    assign w_slot_x   = {1'b0, i_req.slot};
    assign w_in_range = (w_slot_x < SX_W'(NUM_SLOTS));
    assign w_slot_idx = w_slot_x[AW-1:0];

    assign w_rd_en   = i_cmd.end_rd || i_cmd.snap_start || i_cmd.scan_rd;
    assign w_rd_addr = i_cmd.end_rd ? w_slot_idx : i_scan_addr;

    // an entry never written since reset reads as idle
    assign w_rd_id = r_rd_val ? r_rd_data : '0;
    assign w_hit   = (w_rd_id != '0)
                     && !(r_req_in_range && (SX_W'(r_rd_idx) == r_req_slot));

    // slot memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.add && w_in_range) begin
            mem[w_slot_idx] <= i_req.txn_id;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
            r_rd_val  <= r_valid[w_rd_addr];
            r_rd_idx  <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.add && w_in_range) begin
            r_valid[w_slot_idx] <= 1'b1;
        end else if (i_cmd.end_upd && r_req_in_range) begin
            r_valid[r_req_slot[AW-1:0]] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.end_rd || i_cmd.snap_start) begin
            r_req_slot     <= w_slot_x;
            r_req_in_range <= w_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latest_done  <= '0;
            r_next_id      <= ID_W'(1);
            r_reject_floor <= '0;
        end else begin
            if (i_cmd.end_upd && r_req_in_range && (r_latest_done < w_rd_id)) begin
                r_latest_done <= w_rd_id;
            end
            if (i_cmd.assign_id) begin
                r_next_id <= r_next_id + ID_W'(1);
            end
            if (i_cfg_wr) begin
                r_reject_floor <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_min = r_min;
        if (i_cmd.scan_chk && w_hit && (w_rd_id < r_min)) begin
            n_min = w_rd_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.snap_start) begin
            r_ub  <= r_latest_done + ID_W'(1);
            r_min <= r_latest_done + ID_W'(1);
            r_cnt <= '0;
        end else if (i_cmd.scan_chk) begin
            r_min <= n_min;
            if (w_hit) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_rsp       = '0;
        n_rsp_valid = 1'b0;
        if (i_cmd.assign_id) begin
            n_rsp_valid    = 1'b1;
            n_rsp.entry_id = (r_next_id <= r_reject_floor) ? '0 : r_next_id;
            n_rsp.is_last  = 1'b1;
        end else if (i_cmd.scan_chk && w_hit) begin
            n_rsp_valid    = 1'b1;
            n_rsp.entry_id = w_rd_id;
        end else if (i_cmd.emit_sum) begin
            n_rsp_valid        = 1'b1;
            n_rsp.active_count = r_cnt;
            n_rsp.min_active   = r_min;
            n_rsp.upper_bound  = r_ub;
            n_rsp.is_last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp       = r_rsp;
    assign o_rsp_valid = r_rsp_valid;
    assign o_floor     = r_reject_floor;

endmodule

// ----- rtl/core/transaction_snapshot_table.sv -----
// top level of the transaction snapshot table: apb register port, controller and datapath
// depends on tst_pkg, tst_ctrl, tst_dp
//
//   channel   | handshake                             | payload
//   ----------+---------------------------------------+------------------------------
//   request   | start, busy (taken when start & !busy) | i_req (t_req)
//   result    | o_result_valid, one cycle, no stall    | o_rsp (t_rsp)
//   config    | psel, penable, pwrite, pready          | paddr, pwdata, prdata
//
// add is taken with busy staying low; assign likewise, its result shows the cycle
// after the request. end keeps busy high through its update state (slot read then update).
// snapshot does one memory read per slot, then the summary. the slot memory has
// one read port, which sets the scan rate.
// reset is synchronous; valid bits clear every slot at once, no clearing pass.
// results cannot be held off by the receiver.
module transaction_snapshot_table import tst_pkg::*; #(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_result_valid,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(NUM_SLOTS);

    t_cmd            w_cmd;
    logic [AW-1:0]   w_scan_addr;
    logic [ID_W-1:0] w_floor;
    logic            w_cfg_wr;

    assign pready   = 1'b1;
    // only the floor register sits below byte address 4
    assign w_cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata   = paddr[2] ? '0 : w_floor;

    tst_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req_type  (i_req.req_type),
        .o_busy      (busy),
        .o_cmd       (w_cmd),
        .o_scan_addr (w_scan_addr)
    );

    tst_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .AW        (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_scan_addr (w_scan_addr),
        .i_req       (i_req),
        .i_cfg_wr    (w_cfg_wr),
        .i_cfg_data  (pwdata),
        .o_floor     (w_floor),
        .o_rsp       (o_rsp),
        .o_rsp_valid (o_result_valid)
    );

endmodule
